// ===== src/pva_pkg.sv =====
// Package for the polyphonic voice allocator: sizes, slot encoding,
// controller/datapath command and status structs, note math helpers.
// No dependencies.
`default_nettype none
package pva_pkg;

   localparam int VOICES_DEF = 6;
   localparam int NOTE_W     = 7;
   localparam int CHAN_W     = 5;
   localparam int VOICE_W    = 4;
   localparam int OCT_W      = 5;
   localparam int FREQ_W     = 11;
   localparam int SLOT_W     = 8;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [SLOT_W-1:0] SLOT_FREE = 8'd255;
   localparam logic              OP_NOTE_ON  = 1'b0;
   localparam logic              OP_NOTE_OFF = 1'b1;
   localparam logic              CSR_IDX_MONO_MODE = 1'b0;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic mono;
   } dp_stat_type;

   // note / 12 for notes below 128 via reciprocal 171/2048
   function automatic logic [3:0] note_div12(input logic [NOTE_W-1:0] note);
      logic [14:0] prod;
      prod = 15'(note) * 15'd171;
      return prod[14:11];
   endfunction

   function automatic logic [FREQ_W-1:0] freq_lookup(input logic [3:0] step);
      logic [FREQ_W-1:0] fn;
      case (step)
         4'd0:    fn = 11'd617;
         4'd1:    fn = 11'd653;
         4'd2:    fn = 11'd692;
         4'd3:    fn = 11'd733;
         4'd4:    fn = 11'd777;
         4'd5:    fn = 11'd823;
         4'd6:    fn = 11'd872;
         4'd7:    fn = 11'd924;
         4'd8:    fn = 11'd979;
         4'd9:    fn = 11'd1037;
         4'd10:   fn = 11'd1099;
         4'd11:   fn = 11'd1164;
         default: fn = 11'd0;
      endcase
      return fn;
   endfunction

endpackage
`default_nettype wire

// ===== src/pva_ctrl.sv =====
// Controller state machine for the voice allocator: accepts a transaction,
// steps the slot search, and issues the finish command. Uses pva_pkg.
`default_nettype none
module pva_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output pva_pkg::dp_cmd_type       cmd,
   input  wire pva_pkg::dp_stat_type stat
);
   import pva_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.mono || stat.hit || stat.last) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ===== src/pva_dp.sv =====
// Datapath for the voice allocator: captured event, slot table, search
// index, note math and result registers. Uses pva_pkg.
`default_nettype none
module pva_dp #(
   parameter int VOICES = pva_pkg::VOICES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pva_pkg::dp_cmd_type               cmd,
   output pva_pkg::dp_stat_type                   stat,
   input  wire logic                              mono_mode,
   input  wire logic                              in_operation,
   input  wire logic [pva_pkg::CHAN_W-1:0]        in_midi_channel,
   input  wire logic [pva_pkg::NOTE_W-1:0]        in_note,
   output logic                                   out_valid,
   output logic                                   out_accepted,
   output logic                                   out_key_on,
   output logic [pva_pkg::VOICE_W-1:0]            out_voice,
   output logic signed [pva_pkg::OCT_W-1:0]       out_octave,
   output logic [pva_pkg::FREQ_W-1:0]             out_freq_number
);
   import pva_pkg::*;

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

   logic              op_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [NOTE_W-1:0] note_ff;
   logic              mono_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [SLOT_W-1:0] slot_ff [VOICES];

   logic              valid_ff;
   logic              accepted_ff;
   logic              key_on_ff;
   logic [VOICE_W-1:0] voice_ff;
   logic [OCT_W-1:0]  octave_ff;
   logic [FREQ_W-1:0] freq_ff;

   logic [SLOT_W-1:0] cur_slot;
   logic [SLOT_W-1:0] target;
   logic              key_on_in;
   logic              accepted_in;
   logic [VOICE_W-1:0] voice_in;
   logic [3:0]        quot;
   logic [NOTE_W-1:0] rem_full;

   assign cur_slot  = slot_ff[idx_ff];
   assign target    = (op_ff == OP_NOTE_ON) ? SLOT_FREE : {1'b0, note_ff};
   assign stat.hit  = (cur_slot == target);
   assign stat.last = (idx_ff == IDX_W'(VOICES - 1));
   assign stat.mono = mono_ff;

   assign quot     = note_div12(note_ff);
   assign rem_full = note_ff - (NOTE_W'(quot) * NOTE_W'(12));

   always_comb begin
      accepted_in = mono_ff || stat.hit;
      key_on_in   = accepted_in && (op_ff == OP_NOTE_ON);
      if (mono_ff) begin
         voice_in = VOICE_W'(chan_ff - CHAN_W'(1));
      end else if (stat.hit) begin
         voice_in = VOICE_W'(idx_ff);
      end else begin
         voice_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= in_operation;
         chan_ff <= in_midi_channel;
         note_ff <= in_note;
         mono_ff <= mono_mode;
      end
      if (cmd.finish) begin
         accepted_ff <= accepted_in;
         key_on_ff   <= key_on_in;
         voice_ff    <= voice_in;
         octave_ff   <= key_on_in ? (OCT_W'(quot) - OCT_W'(1)) : '0;
         freq_ff     <= key_on_in ? freq_lookup(rem_full[3:0]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            slot_ff[i] <= SLOT_FREE;
         end
      end else begin
         valid_ff <= cmd.finish;
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.step) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.finish && !mono_ff && stat.hit) begin
            slot_ff[idx_ff] <= (op_ff == OP_NOTE_ON) ? {1'b0, note_ff} : SLOT_FREE;
         end
      end
   end

   assign out_valid       = valid_ff;
   assign out_accepted    = accepted_ff;
   assign out_key_on      = key_on_ff;
   assign out_voice       = voice_ff;
   assign out_octave      = signed'(octave_ff);
   assign out_freq_number = freq_ff;

endmodule
`default_nettype wire

// ===== src/poly_voice_allocator_core.sv =====
// Top level of the polyphonic voice allocator: CSR port, controller and
// datapath. Depends on pva_pkg, pva_ctrl and pva_dp.
//
// An event is taken when start is high and busy is low. A polyphonic event
// scans the slot table one slot per cycle until it finds a free slot (note on)
// or the lowest slot holding the note (note off), or reaches the last slot;
// a mono event skips the scan. The result appears on the rsp_ ports for
// exactly one cycle, marked by rsp_valid, in the same cycle that busy drops;
// the receiver cannot stall it, and a new event may be started in that
// same cycle. Every event yields one result, with rsp_accepted low when no
// slot was free or no slot matched. mono_mode lives at byte address 0 and may
// only be written while busy is low and no result is pending.
`default_nettype none
module poly_voice_allocator_core #(
   parameter int VOICES = pva_pkg::VOICES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_operation,
   input  wire logic [pva_pkg::CHAN_W-1:0]    req_midi_channel,
   input  wire logic [pva_pkg::NOTE_W-1:0]    req_note,
   output logic                               rsp_valid,
   output logic                               rsp_accepted,
   output logic                               rsp_key_on,
   output logic [pva_pkg::VOICE_W-1:0]        rsp_voice,
   output logic signed [pva_pkg::OCT_W-1:0]   rsp_octave,
   output logic [pva_pkg::FREQ_W-1:0]         rsp_freq_number,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [pva_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [pva_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pva_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);
   import pva_pkg::*;

   logic        mono_mode_ff;
   logic        csr_sel_mono;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_pready   = 1'b1;
   assign csr_sel_mono = (csr_paddr[2] == CSR_IDX_MONO_MODE) && (csr_paddr[1:0] == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_mode_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_mono) begin
         mono_mode_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = csr_sel_mono ? {{(CSR_DW-1){1'b0}}, mono_mode_ff} : '0;

   pva_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   pva_dp #(
      .VOICES (VOICES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .mono_mode       (mono_mode_ff),
      .in_operation    (req_operation),
      .in_midi_channel (req_midi_channel),
      .in_note         (req_note),
      .out_valid       (rsp_valid),
      .out_accepted    (rsp_accepted),
      .out_key_on      (rsp_key_on),
      .out_voice       (rsp_voice),
      .out_octave      (rsp_octave),
      .out_freq_number (rsp_freq_number)
   );

   a_finish_strobes: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finish without result strobe");

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_follows_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction in flight");

   a_key_off_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_key_on) |-> (rsp_octave == '0 && rsp_freq_number == '0))
      else $error("key off result carries pitch");

   a_key_on_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_on) |-> rsp_accepted)
      else $error("key on without accepted");

endmodule
`default_nettype wire
